>>> design/bezier_midpoint_subdivider_unit_assert.svh
// Assertion macros for the midpoint subdivider.
// Both macros expect clk and rst_n in the scope where they are used.
`ifndef BEZIER_MIDPOINT_SUBDIVIDER_UNIT_ASSERT_SVH
`define BEZIER_MIDPOINT_SUBDIVIDER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bms_pkg.sv
package bms_pkg;

    localparam int COORD_BITS = 24;
    localparam int MAX_LEVELS = 4;
    localparam int SEG_PTS    = 4;
    localparam int LVL_W      = 3;
    localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
    localparam int IDX_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    localparam logic [LVL_W-1:0] LEVELS_RESET = LVL_W'(2);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // Element 0 is the first control point of the segment.
    typedef point_t [SEG_PTS-1:0] seg_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t ctrl_a_x;
        coord_t ctrl_a_y;
        coord_t ctrl_a_z;
        coord_t ctrl_b_x;
        coord_t ctrl_b_y;
        coord_t ctrl_b_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
    } curve_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        logic   final_point;
    } point_out_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

    typedef struct packed {
        seg_t             seg;
        logic [LVL_W-1:0] lvl;
    } stk_entry_t;

endpackage

>>> design/bezier_midpoint_subdivider_unit.sv
// Cubic Bezier midpoint subdivider. One transfer on the curve channel carries
// four 3-D control points (signed 24-bit fixed point). The curve is split at
// t = 1/2 by de Casteljau floor averaging, depth-first, to L levels, where L is
// the cfg register (reset 2, values above 4 act as 4). The 2^L leaf segments
// leave on the point channel left to right, four points per leaf, with
// final_point set on the very last one; L = 0 passes the curve through as four
// points. A single three-lane averager does all the arithmetic, one averaging
// step at a time, and each split is followed by a decision step. The curve
// channel is ready only between curves; the last point of a curve may still
// wait in the output register while the next curve is taken in. cfg_wdata is
// written whenever cfg_we is high and must only change between curves.
module bezier_midpoint_subdivider_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bms_pkg::LVL_W-1:0] cfg_wdata,
    input  logic                      curve_valid,
    output logic                      curve_ready,
    input  bms_pkg::curve_t           curve,
    output logic                      point_valid,
    input  logic                      point_ready,
    output bms_pkg::point_out_t       point
);
    import bms_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_SPLIT  = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    // averaging steps of one split; the step number is also the scratch slot
    localparam logic [2:0] STEP_A = 3'd0;  // avg(Q0,Q1)
    localparam logic [2:0] STEP_M = 3'd1;  // avg(Q1,Q2)
    localparam logic [2:0] STEP_B = 3'd2;  // avg(Q2,Q3)
    localparam logic [2:0] STEP_C = 3'd3;  // avg(a,m)
    localparam logic [2:0] STEP_D = 3'd4;  // avg(m,b)
    localparam logic [2:0] STEP_E = 3'd5;  // avg(c,d), the midpoint itself

    localparam int          TMP_N   = 5;
    localparam logic [1:0]  LAST_PT = 2'(SEG_PTS - 1);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [LVL_W-1:0]  levels_reg;
    logic [LVL_W-1:0]  levels_next;
    logic [LVL_W-1:0]  levels_eff;
    logic [LVL_W-1:0]  lvl_reg;
    logic [LVL_W-1:0]  lvl_next;
    logic [2:0]        step_reg;
    logic [2:0]        step_next;
    logic [1:0]        pidx_reg;
    logic [1:0]        pidx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    point_out_t        out_reg;
    point_out_t        out_next;
    seg_t              cur_reg;
    seg_t              cur_next;
    point_t            tmp_reg [TMP_N];

    seg_t              in_seg;
    seg_t              left_seg;
    seg_t              right_seg;
    point_t            op_a;
    point_t            op_b;
    point_t            avg_out;
    logic              emit_load;
    logic              last_pt;
    logic              stk_empty;
    stk_ctrl_t         stk_ctrl;
    stk_entry_t        push_entry;
    stk_entry_t        top_entry;
    logic [CNT_W-1:0]  stk_count;

    // ------------------------------------------------------------------
    // Shared datapath: one averager and the stack of pending right halves
    // ------------------------------------------------------------------
    bms_avg u_avg (
        .a (op_a),
        .b (op_b),
        .y (avg_out)
    );

    bms_stack u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stk_ctrl),
        .push_entry (push_entry),
        .top_entry  (top_entry),
        .count      (stk_count)
    );

    // incoming curve as a segment, P0 in element 0
    assign in_seg[0] = {curve.start_x,  curve.start_y,  curve.start_z};
    assign in_seg[1] = {curve.ctrl_a_x, curve.ctrl_a_y, curve.ctrl_a_z};
    assign in_seg[2] = {curve.ctrl_b_x, curve.ctrl_b_y, curve.ctrl_b_z};
    assign in_seg[3] = {curve.end_x,    curve.end_y,    curve.end_z};

    // depth saturates at the stack depth
    assign levels_eff = (levels_reg > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : levels_reg;

    // operand selection for the averager
    always_comb
    begin
        unique case (step_reg)
            STEP_A:
            begin
                op_a = cur_reg[0];
                op_b = cur_reg[1];
            end
            STEP_M:
            begin
                op_a = cur_reg[1];
                op_b = cur_reg[2];
            end
            STEP_B:
            begin
                op_a = cur_reg[2];
                op_b = cur_reg[3];
            end
            STEP_C:
            begin
                op_a = tmp_reg[STEP_A];
                op_b = tmp_reg[STEP_M];
            end
            STEP_D:
            begin
                op_a = tmp_reg[STEP_M];
                op_b = tmp_reg[STEP_B];
            end
            default:
            begin
                op_a = tmp_reg[STEP_C];
                op_b = tmp_reg[STEP_D];
            end
        endcase
    end

    // halves, valid in the STEP_E cycle where avg_out is the midpoint e
    always_comb
    begin
        left_seg[0]  = cur_reg[0];
        left_seg[1]  = tmp_reg[STEP_A];
        left_seg[2]  = tmp_reg[STEP_C];
        left_seg[3]  = avg_out;
        right_seg[0] = avg_out;
        right_seg[1] = tmp_reg[STEP_D];
        right_seg[2] = tmp_reg[STEP_B];
        right_seg[3] = cur_reg[3];
    end

    assign push_entry = '{seg: right_seg, lvl: lvl_reg + LVL_W'(1)};

    // a point is loaded into the output register whenever it is free or freeing
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || point_ready);
    assign last_pt   = (pidx_reg == LAST_PT);
    assign stk_empty = (stk_count == '0);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        levels_next    = cfg_we ? cfg_wdata : levels_reg;
        lvl_next       = lvl_reg;
        step_next      = step_reg;
        pidx_next      = pidx_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !point_ready;
        out_next       = out_reg;
        stk_ctrl       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (curve_valid)
                begin
                    cur_next   = in_seg;
                    lvl_next   = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // split further, or the current segment is a leaf
                if (lvl_reg < levels_eff)
                begin
                    step_next  = STEP_A;
                    state_next = ST_SPLIT;
                end
                else
                begin
                    pidx_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_SPLIT:
            begin
                if (step_reg == STEP_E)
                begin
                    // right half waits on the stack, carry on with the left
                    stk_ctrl.push = 1'b1;
                    cur_next      = left_seg;
                    lvl_next      = lvl_reg + LVL_W'(1);
                    state_next    = ST_DECIDE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next       = 1'b1;
                    out_next.point_x     = cur_reg[pidx_reg].x;
                    out_next.point_y     = cur_reg[pidx_reg].y;
                    out_next.point_z     = cur_reg[pidx_reg].z;
                    out_next.final_point = last_pt && stk_empty;
                    pidx_next            = pidx_reg + 2'd1;
                    if (last_pt)
                    begin
                        if (stk_empty)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            // next leaf-or-subtree is the most recent right half
                            stk_ctrl.pop = 1'b1;
                            cur_next     = top_entry.seg;
                            lvl_next     = top_entry.lvl;
                            state_next   = ST_DECIDE;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            levels_reg    <= LEVELS_RESET;
            lvl_reg       <= '0;
            step_reg      <= STEP_A;
            pidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            levels_reg    <= levels_next;
            lvl_reg       <= lvl_next;
            step_reg      <= step_next;
            pidx_reg      <= pidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
        if ((state_reg == ST_SPLIT) && (step_reg != STEP_E))
        begin
            tmp_reg[step_reg] <= avg_out;
        end
    end

    assign curve_ready = (state_reg == ST_IDLE);
    assign point_valid = out_valid_reg;
    assign point       = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "bezier_midpoint_subdivider_unit_assert.svh"

    `BMS_ASSERT_IMP(a_idle_stack_empty, curve_ready, stk_count == '0, "stack not empty between curves")
    `BMS_ASSERT_IMP(a_stack_within_depth, state_reg != ST_IDLE, stk_count <= CNT_W'(lvl_reg), "stack deeper than level")
    `BMS_ASSERT_NXT(a_final_then_idle, emit_load && last_pt && stk_empty, curve_ready && point_valid && point.final_point, "final point not followed by idle")

endmodule

>>> design/bms_avg.sv
// Floor average of two points, all three lanes at once.
module bms_avg (
    input  bms_pkg::point_t a,
    input  bms_pkg::point_t b,
    output bms_pkg::point_t y
);
    import bms_pkg::*;

    logic [COORD_BITS:0] sum_x;
    logic [COORD_BITS:0] sum_y;
    logic [COORD_BITS:0] sum_z;

    // sign-extend by one bit, add, drop the lsb
    assign sum_x = {a.x[COORD_BITS-1], a.x} + {b.x[COORD_BITS-1], b.x};
    assign sum_y = {a.y[COORD_BITS-1], a.y} + {b.y[COORD_BITS-1], b.y};
    assign sum_z = {a.z[COORD_BITS-1], a.z} + {b.z[COORD_BITS-1], b.z};

    assign y.x = sum_x[COORD_BITS:1];
    assign y.y = sum_y[COORD_BITS:1];
    assign y.z = sum_z[COORD_BITS:1];

endmodule

>>> design/bms_stack.sv
// Pending right halves, one entry per level of depth.
module bms_stack (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bms_pkg::stk_ctrl_t        ctrl,
    input  bms_pkg::stk_entry_t       push_entry,
    output bms_pkg::stk_entry_t       top_entry,
    output logic [bms_pkg::CNT_W-1:0] count
);
    import bms_pkg::*;

    stk_entry_t       mem_reg [MAX_LEVELS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] top_pos;

    assign top_pos   = cnt_reg[IDX_W-1:0] - IDX_W'(1);
    assign top_entry = mem_reg[top_pos];
    assign count     = cnt_reg;

    always_comb
    begin
        priority if (ctrl.push)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem_reg[cnt_reg[IDX_W-1:0]] <= push_entry;
        end
    end

endmodule
